// ----- hdl/izr_pkg.sv -----
package izr_pkg;

  // rotation stages of the cordic
  localparam int CordicStages = 16;

  // restoring divider lengths, one quotient bit per stage
  localparam int MagDivSteps  = 64;
  localparam int ResDivSteps  = 96;
  localparam int ElemDivSteps = 64;

  localparam logic [47:0] Max48S  = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] Max48U  = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] CordicK = 32'd2608131496;
  localparam logic [63:0] CapNum  = 64'd10430378350470452725;
  localparam logic [43:0] IndNum  = 44'd10430378350470;
  localparam logic [21:0] IndLo   = IndNum[21:0];
  localparam logic [21:0] IndHi   = IndNum[43:22];
  localparam logic [5:0]  AngDiv  = 6'd45;

  // angle scaling: (a*2^21 + 22)/45 = a*46603 + (a*17 + 22)/45
  localparam logic [15:0] AngWhole = 16'd46603;
  localparam logic [4:0]  AngFrac  = 5'd17;
  localparam logic [4:0]  AngRound = 5'd22;
  // ceil(2^27/45), exact for the fractional term below 2^21
  localparam logic [21:0] AngRecip = 22'd2982617;
  localparam int          AngShift = 27;

  // status codes
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StSat      = 2'd1;
  localparam logic [1:0] StZeroFreq = 2'd2;

  // arctangent of 2^-i as a 32 bit binary angle
  localparam logic [30:0] Atan [32] = '{
    31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756,
    31'd42667331,  31'd21354465,  31'd10679838,  31'd5340245,
    31'd2670163,   31'd1335087,   31'd667544,    31'd333772,
    31'd166886,    31'd83443,     31'd41722,     31'd20861,
    31'd10430,     31'd5215,      31'd2608,      31'd1304,
    31'd652,       31'd326,       31'd163,       31'd81,
    31'd41,        31'd20,        31'd10,        31'd5,
    31'd3,         31'd1,         31'd1,         31'd0
  };

  typedef struct packed {
    logic [23:0]        ratio;
    logic signed [16:0] phase;
    logic [15:0]        vg;
    logic [23:0]        tz;
    logic [15:0]        cg;
    logic [19:0]        f;
  } in_t;

  // vector in flight through the cordic
  typedef struct packed {
    logic signed [49:0] x;
    logic signed [49:0] y;
    logic signed [33:0] z;
    logic               sat;
    logic [63:0]        capq;
    logic [19:0]        f;
  } cd_t;

  typedef struct packed {
    logic signed [47:0] real_part;
    logic signed [47:0] imag_part;
    logic               is_cap;
    logic [47:0]        elem;
    logic signed [47:0] eqr;
    logic [1:0]         status;
  } out_t;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [48:0] div_step(input logic [47:0] rem, input logic b,
                                           input logic [47:0] d);
    logic [48:0] t;
    t = {rem, b};
    if (t >= {1'b0, d}) begin
      div_step = {1'b1, t[47:0] - d};
    end else begin
      div_step = {1'b0, t[47:0]};
    end
  endfunction

endpackage

// ----- hdl/izr_front.sv -----
module izr_front import izr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  in_t  in_i,
  output logic valid_o,
  output cd_t  out_o
);

  typedef struct packed {
    logic [47:0] p1;
    logic [15:0] cg;
    logic [15:0] vg;
    logic [31:0] ah;
    logic [20:0] av;
    logic        ppos;
    logic [19:0] f;
  } s1_t;

  typedef struct packed {
    logic [63:0] mag_num;
    logic [15:0] mag_rem;
    logic [15:0] vg;
    logic [31:0] an;
    logic        ppos;
    logic [19:0] f;
    logic [63:0] cn;
    logic [19:0] cn_rem;
  } dv_t;

  typedef struct packed {
    logic [62:0]        ph;
    logic [47:0]        pl;
    logic               neg;
    logic signed [33:0] z;
    logic               sat;
    logic [63:0]        capq;
    logic [19:0]        f;
  } m1_t;

  s1_t s1_d, s1_q;
  dv_t dv_d0;
  dv_t dv_q [MagDivSteps+1];
  m1_t m1_d, m1_q;
  cd_t out_d, out_q;
  logic s1_vq, m1_vq, out_vq;
  logic [MagDivSteps:0] dv_vq;

  // gains, first product, angle whole and fractional terms
  always_comb begin
    logic [23:0] tz;
    logic [15:0] cg, vg;
    logic [16:0] a_abs;
    tz = (in_i.tz == '0) ? 24'd1 : in_i.tz;
    cg = (in_i.cg == '0) ? 16'd1 : in_i.cg;
    vg = (in_i.vg == '0) ? 16'd1 : in_i.vg;
    a_abs = in_i.phase[16] ? 17'(-in_i.phase) : 17'(in_i.phase);
    s1_d.p1   = 48'(in_i.ratio) * 48'(tz);
    s1_d.cg   = cg;
    s1_d.vg   = vg;
    s1_d.ah   = 32'(a_abs) * 32'(AngWhole);
    s1_d.av   = 21'(a_abs) * 21'(AngFrac) + 21'(AngRound);
    s1_d.ppos = !in_i.phase[16] && (in_i.phase != '0);
    s1_d.f    = in_i.f;
  end

  always_comb begin
    logic [42:0] fr;
    fr = 43'(s1_q.av) * 43'(AngRecip);
    dv_d0.mag_num = 64'(s1_q.p1) * 64'(s1_q.cg);
    dv_d0.mag_rem = '0;
    dv_d0.vg      = s1_q.vg;
    dv_d0.an      = s1_q.ah + 32'(fr[42:AngShift]);
    dv_d0.ppos    = s1_q.ppos;
    dv_d0.f       = s1_q.f;
    dv_d0.cn      = CapNum;
    dv_d0.cn_rem  = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q     <= s1_d;
      dv_q[0]  <= dv_d0;
    end
  end

  // magnitude / vg and capacitance constant / f side by side
  for (genvar k = 1; k <= MagDivSteps; k++) begin : g_div
    dv_t nxt;
    always_comb begin
      logic [48:0] ms, cs;
      nxt = dv_q[k-1];
      ms = div_step(48'(dv_q[k-1].mag_rem), dv_q[k-1].mag_num[63], 48'(dv_q[k-1].vg));
      nxt.mag_num = {dv_q[k-1].mag_num[62:0], ms[48]};
      nxt.mag_rem = ms[15:0];
      cs = div_step(48'(dv_q[k-1].cn_rem), dv_q[k-1].cn[63], 48'(dv_q[k-1].f));
      nxt.cn     = {dv_q[k-1].cn[62:0], cs[48]};
      nxt.cn_rem = cs[19:0];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[k] <= nxt;
      end
    end
  end

  // saturate, quadrant fold, gain compensation products
  always_comb begin
    logic [63:0] mag;
    logic [46:0] m47;
    logic [31:0] a, u;
    logic signed [31:0] zs;
    logic big;
    mag = dv_q[MagDivSteps].mag_num;
    m1_d.sat = mag > 64'(Max48S);
    m47 = m1_d.sat ? Max48S[46:0] : mag[46:0];
    a  = dv_q[MagDivSteps].an;
    u  = dv_q[MagDivSteps].ppos ? (32'd0 - a) : a;
    zs = signed'(u);
    big = (zs > 32'sh4000_0000) || (zs < -32'sh4000_0000);
    m1_d.neg = big;
    m1_d.z = 34'(zs);
    if (big) begin
      m1_d.z = zs[31] ? (34'(zs) + 34'sh8000_0000) : (34'(zs) - 34'sh8000_0000);
    end
    m1_d.ph   = 63'(m47[46:16]) * 63'(CordicK);
    m1_d.pl   = 48'(m47[15:0]) * 48'(CordicK);
    m1_d.capq = dv_q[MagDivSteps].cn;
    m1_d.f    = dv_q[MagDivSteps].f;
  end

  always_comb begin
    logic [63:0] xs;
    logic [49:0] xu;
    xs = (64'(m1_q.ph) + 64'(m1_q.pl[47:16]) + 64'h8000) >> 16;
    xu = 50'(xs[47:0]);
    out_d.x    = m1_q.neg ? (50'd0 - xu) : xu;
    out_d.y    = '0;
    out_d.z    = m1_q.z;
    out_d.sat  = m1_q.sat;
    out_d.capq = m1_q.capq;
    out_d.f    = m1_q.f;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q  <= m1_d;
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vq  <= 1'b0;
      dv_vq  <= '0;
      m1_vq  <= 1'b0;
      out_vq <= 1'b0;
    end else if (en_i) begin
      s1_vq  <= valid_i;
      dv_vq  <= {dv_vq[MagDivSteps-1:0], s1_vq};
      m1_vq  <= dv_vq[MagDivSteps];
      out_vq <= m1_vq;
    end
  end

  assign valid_o = out_vq;
  assign out_o   = out_q;

endmodule

// ----- hdl/izr_cordic.sv -----
module izr_cordic import izr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  cd_t  in_i,
  output logic valid_o,
  output cd_t  out_o
);

  cd_t stg_q [CordicStages];
  logic [CordicStages-1:0] v_q;

  for (genvar i = 0; i < CordicStages; i++) begin : g_stage
    cd_t prev, nxt;
    if (i == 0) begin : g_first
      assign prev = in_i;
    end else begin : g_rest
      assign prev = stg_q[i-1];
    end
    always_comb begin
      logic signed [49:0] x, y, xs, ys;
      logic signed [33:0] ang;
      x   = prev.x;
      y   = prev.y;
      xs  = x >>> i;
      ys  = y >>> i;
      ang = signed'({3'b000, Atan[i]});
      nxt = prev;
      if (!prev.z[33]) begin
        nxt.x = x - ys;
        nxt.y = y + xs;
        nxt.z = prev.z - ang;
      end else begin
        nxt.x = x + ys;
        nxt.y = y - xs;
        nxt.z = prev.z + ang;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[i] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[CordicStages-2:0], valid_i};
    end
  end

  assign valid_o = v_q[CordicStages-1];
  assign out_o   = stg_q[CordicStages-1];

endmodule

// ----- hdl/izr_back.sv -----
module izr_back import izr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  cd_t  in_i,
  output logic valid_o,
  output out_t out_o
);

  typedef struct packed {
    logic signed [47:0] r;
    logic signed [47:0] y;
    logic [47:0]        ar;
    logic [47:0]        ax;
    logic               cap;
    logic               rz;
    logic               sat;
    logic [63:0]        capq;
    logic [19:0]        f;
  } b1_t;

  typedef struct packed {
    logic [47:0] arhh, arhl, arll;
    logic [47:0] axhh, axhl, axll;
    logic [47:0] phh, phl, plh, pll;
    b1_t         c;
  } b2_t;

  typedef struct packed {
    logic [95:0] ar2;
    logic [95:0] ax2;
    logic [91:0] pi;
    b1_t         c;
  } b3_t;

  typedef struct packed {
    logic [95:0]        rn;
    logic [47:0]        rrem;
    logic [47:0]        ar;
    logic [63:0]        en;
    logic [47:0]        erem;
    logic [47:0]        ed;
    logic signed [47:0] r;
    logic signed [47:0] y;
    logic               cap;
    logic               rz;
    logic               sat;
    logic [19:0]        f;
  } dv_t;

  b1_t  b1_d, b1_q;
  b2_t  b2_d, b2_q;
  b3_t  b3_d, b3_q;
  dv_t  dv_d0;
  dv_t  dv_q [ResDivSteps+1];
  out_t out_d, out_q;
  logic b1_vq, b2_vq, b3_vq, out_vq;
  logic [ResDivSteps:0] dv_vq;

  // clamp to 48 bits, absolute values
  always_comb begin
    logic sat;
    sat = in_i.sat;
    if (in_i.x > 50'sh0_7FFF_FFFF_FFFF) begin
      b1_d.r = Max48S; sat = 1'b1;
    end else if (in_i.x < -50'sh0_8000_0000_0000) begin
      b1_d.r = ~Max48S; sat = 1'b1;
    end else begin
      b1_d.r = in_i.x[47:0];
    end
    if (in_i.y > 50'sh0_7FFF_FFFF_FFFF) begin
      b1_d.y = Max48S; sat = 1'b1;
    end else if (in_i.y < -50'sh0_8000_0000_0000) begin
      b1_d.y = ~Max48S; sat = 1'b1;
    end else begin
      b1_d.y = in_i.y[47:0];
    end
    b1_d.sat  = sat;
    b1_d.cap  = b1_d.y[47];
    b1_d.ax   = 48'd0 - b1_d.y;
    b1_d.ar   = b1_d.r[47] ? (48'd0 - b1_d.r) : b1_d.r;
    b1_d.rz   = (b1_d.r == '0);
    b1_d.capq = in_i.capq;
    b1_d.f    = in_i.f;
  end

  // partial products of the squares and of the inductance scale
  always_comb begin
    b2_d.arhh = 48'(b1_q.ar[47:24]) * 48'(b1_q.ar[47:24]);
    b2_d.arhl = 48'(b1_q.ar[47:24]) * 48'(b1_q.ar[23:0]);
    b2_d.arll = 48'(b1_q.ar[23:0]) * 48'(b1_q.ar[23:0]);
    b2_d.axhh = 48'(b1_q.ax[47:24]) * 48'(b1_q.ax[47:24]);
    b2_d.axhl = 48'(b1_q.ax[47:24]) * 48'(b1_q.ax[23:0]);
    b2_d.axll = 48'(b1_q.ax[23:0]) * 48'(b1_q.ax[23:0]);
    b2_d.phh  = 48'(b1_q.y[47:24]) * 48'(IndHi);
    b2_d.phl  = 48'(b1_q.y[47:24]) * 48'(IndLo);
    b2_d.plh  = 48'(b1_q.y[23:0]) * 48'(IndHi);
    b2_d.pll  = 48'(b1_q.y[23:0]) * 48'(IndLo);
    b2_d.c    = b1_q;
  end

  always_comb begin
    b3_d.ar2 = {b2_q.arhh, 48'd0} + {23'd0, b2_q.arhl, 25'd0} + 96'(b2_q.arll);
    b3_d.ax2 = {b2_q.axhh, 48'd0} + {23'd0, b2_q.axhl, 25'd0} + 96'(b2_q.axll);
    b3_d.pi  = {b2_q.phh[45:0], 46'd0} + {22'd0, b2_q.phl[45:0], 24'd0}
             + {24'd0, b2_q.plh[45:0], 22'd0} + 92'(b2_q.pll);
    b3_d.c   = b2_q.c;
  end

  // load both dividers
  always_comb begin
    dv_d0.rn   = b3_q.ar2 + b3_q.ax2;
    dv_d0.rrem = '0;
    dv_d0.ar   = b3_q.c.ar;
    dv_d0.en   = b3_q.c.cap ? b3_q.c.capq : 64'(b3_q.pi[91:32]);
    dv_d0.erem = '0;
    dv_d0.ed   = b3_q.c.cap ? b3_q.c.ax : 48'(b3_q.c.f);
    dv_d0.r    = b3_q.c.r;
    dv_d0.y    = b3_q.c.y;
    dv_d0.cap  = b3_q.c.cap;
    dv_d0.rz   = b3_q.c.rz;
    dv_d0.sat  = b3_q.c.sat;
    dv_d0.f    = b3_q.c.f;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_q    <= b1_d;
      b2_q    <= b2_d;
      b3_q    <= b3_d;
      dv_q[0] <= dv_d0;
    end
  end

  for (genvar k = 1; k <= ResDivSteps; k++) begin : g_div
    dv_t nxt;
    always_comb begin
      logic [48:0] rs, es;
      nxt = dv_q[k-1];
      rs = div_step(dv_q[k-1].rrem, dv_q[k-1].rn[95], dv_q[k-1].ar);
      nxt.rn   = {dv_q[k-1].rn[94:0], rs[48]};
      nxt.rrem = rs[47:0];
      es = div_step(dv_q[k-1].erem, dv_q[k-1].en[63], dv_q[k-1].ed);
      if (k <= ElemDivSteps) begin
        nxt.en   = {dv_q[k-1].en[62:0], es[48]};
        nxt.erem = es[47:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[k] <= nxt;
      end
    end
  end

  // saturation, sign and status
  always_comb begin
    logic sat;
    logic [47:0] mag;
    dv_t  s;
    s   = dv_q[ResDivSteps];
    sat = s.sat;
    mag = '0;
    if (s.f == '0) begin
      out_d.elem = '0;
    end else if (s.en > 64'(Max48U)) begin
      out_d.elem = Max48U;
      sat = 1'b1;
    end else begin
      out_d.elem = s.en[47:0];
    end
    if (s.cap) begin
      if (s.rz) begin
        out_d.eqr = Max48S;
        sat = 1'b1;
      end else begin
        if (s.rn > 96'(Max48S)) begin
          mag = Max48S;
          sat = 1'b1;
        end else begin
          mag = s.rn[47:0];
        end
        out_d.eqr = s.r[47] ? (48'd0 - mag) : mag;
      end
    end else begin
      out_d.eqr = s.r;
    end
    out_d.real_part = s.r;
    out_d.imag_part = s.y;
    out_d.is_cap    = s.cap;
    if (s.f == '0) begin
      out_d.status = StZeroFreq;
    end else if (sat) begin
      out_d.status = StSat;
    end else begin
      out_d.status = StOk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vq  <= 1'b0;
      b2_vq  <= 1'b0;
      b3_vq  <= 1'b0;
      dv_vq  <= '0;
      out_vq <= 1'b0;
    end else if (en_i) begin
      b1_vq  <= valid_i;
      b2_vq  <= b1_vq;
      b3_vq  <= b2_vq;
      dv_vq  <= {dv_vq[ResDivSteps-1:0], b3_vq};
      out_vq <= dv_vq[ResDivSteps];
    end
  end

  assign valid_o = out_vq;
  assign out_o   = out_q;

endmodule

// ----- hdl/impedance_from_ratio_and_phase_unit.sv -----
// impedance from amplitude ratio and phase
// input channel: in_valid_i / in_stall_o with one measurement per transfer
// (ratio, phase, three gains, frequency); output channel: out_valid_o /
// out_stall_i with one result per transfer (R, X, capacitive flag, element
// value, equivalent resistance, status)
// the path from input transfer to output valid runs through the front end
// (two gain products, a 64 step divider for the magnitude, 45 degree
// angle scaling and the capacitance constant, then gain compensation),
// 16 cordic rotation stages, and the back end whose 96 step restoring
// divider for the parallel resistance is the longest chain
// throughput is one transfer per cycle unless the receiver stalls a result;
// every stage carries its own valid bit; reset clears all valid bits, so the
// pipeline comes up empty and the output channel shows no transfer; payload
// registers are not reset; while the output holds a result and the receiver
// stalls, the whole pipeline holds and in_stall_o is raised; bubbles keep
// moving otherwise, so an empty output stage never blocks the input
module impedance_from_ratio_and_phase_unit import izr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [23:0]        amplitude_ratio_i,
  input  logic signed [16:0] phase_deg_i,
  input  logic [15:0]        voltage_gain_i,
  input  logic [23:0]        transimpedance_gain_i,
  input  logic [15:0]        current_gain_i,
  input  logic [19:0]        frequency_hz_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [47:0] real_part_o,
  output logic signed [47:0] imag_part_o,
  output logic               is_capacitive_o,
  output logic [47:0]        element_value_o,
  output logic signed [47:0] equivalent_resistance_o,
  output logic [1:0]         status_o
);

  in_t  meas;
  cd_t  front_out, cordic_out;
  out_t result;
  logic front_valid, cordic_valid;
  logic adv;

  // pipeline moves unless a finished result is held by the receiver
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  assign meas.ratio = amplitude_ratio_i;
  assign meas.phase = phase_deg_i;
  assign meas.vg    = voltage_gain_i;
  assign meas.tz    = transimpedance_gain_i;
  assign meas.cg    = current_gain_i;
  assign meas.f     = frequency_hz_i;

  // magnitude, angle and capacitance constant
  izr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .in_i    (meas),
    .valid_o (front_valid),
    .out_o   (front_out)
  );

  // polar to rectangular
  izr_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (front_valid),
    .in_i    (front_out),
    .valid_o (cordic_valid),
    .out_o   (cordic_out)
  );

  // element value, equivalent resistance, status; ends in the output register
  izr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (cordic_valid),
    .in_i    (cordic_out),
    .valid_o (out_valid_o),
    .out_o   (result)
  );

  assign real_part_o             = result.real_part;
  assign imag_part_o             = result.imag_part;
  assign is_capacitive_o         = result.is_cap;
  assign element_value_o         = result.elem;
  assign equivalent_resistance_o = result.eqr;
  assign status_o                = result.status;

endmodule

// ----- sim/testbench.sv -----
module testbench;
  import izr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     NumRandom  = 1700;
  localparam int     IdlePct    = 18;
  // depth of the pipeline
  localparam int     Latency    = 185;
  localparam int     QuietLimit = 4000;
  localparam longint PosLim     = 64'sh7FFF_FFFF_FFFF;
  localparam longint NegLim     = -PosLim - 1;

  // scoreboard: expected results in arrival order
  class impedance_scoreboard;
    out_t pending[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    task report(string what, logic [47:0] got, logic [47:0] want);
      errors++;
      $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // accepted measurement, queue its impedance
    function void note_measurement(in_t m);
      pending.push_back(predict_impedance(m));
    endfunction

    task check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        report("unexpected result", got.real_part, '0);
      end else begin
        want = pending.pop_front();
        if (got.real_part !== want.real_part)
          report("real_part", got.real_part, want.real_part);
        if (got.imag_part !== want.imag_part)
          report("imag_part", got.imag_part, want.imag_part);
        if (got.is_cap !== want.is_cap)
          report("is_capacitive", 48'(got.is_cap), 48'(want.is_cap));
        if (got.elem !== want.elem)
          report("element_value", got.elem, want.elem);
        if (got.eqr !== want.eqr)
          report("equivalent_resistance", got.eqr, want.eqr);
        if (got.status !== want.status)
          report("status", 48'(got.status), 48'(want.status));
      end
    endtask
  endclass

  // bit exact impedance predictor
  function automatic out_t predict_impedance(in_t m);
    logic [63:0]  vg, tz, cg, f, mag, a, u, hi, lo, ax, ar, elem;
    logic [127:0] num, q;
    longint       p, x, y, z, xs, ys, eqr;
    logic         sat, cap;
    out_t         r;
    sat  = 1'b0;
    elem = '0;
    p    = longint'(m.phase);
    vg   = (m.vg == 0) ? 64'd1 : 64'(m.vg);
    tz   = (m.tz == 0) ? 64'd1 : 64'(m.tz);
    cg   = (m.cg == 0) ? 64'd1 : 64'(m.cg);
    f    = 64'(m.f);

    // magnitude in q.16
    mag = (64'(m.ratio) * tz * cg) / vg;
    if (mag > 64'(Max48S)) begin
      mag = 64'(Max48S);
      sat = 1'b1;
    end

    // angle = -phase as a 32 bit binary angle
    a = (p < 0) ? 64'(-p) : 64'(p);
    a = ((a << 21) + 64'd22) / 64'(AngDiv);
    u = (p > 0) ? ((64'd0 - a) & 64'hFFFF_FFFF) : (a & 64'hFFFF_FFFF);
    z = (u >= 64'h8000_0000) ? longint'(u) - 64'sd4294967296 : longint'(u);

    // start vector pre-scaled by the cordic gain
    hi = mag >> 16;
    lo = mag & 64'hFFFF;
    x  = longint'((hi * 64'(CordicK) + ((lo * 64'(CordicK)) >> 16) + 64'h8000) >> 16);
    y  = 0;
    // beyond +-90 degrees: flip the vector and turn by half a circle
    if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
      x = -x;
      z = (z > 0) ? z - 64'sd2147483648 : z + 64'sd2147483648;
    end
    for (int i = 0; i < CordicStages && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(Atan[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(Atan[i]);
      end
    end
    if (x > PosLim) begin x = PosLim; sat = 1'b1; end
    if (x < NegLim) begin x = NegLim; sat = 1'b1; end
    if (y > PosLim) begin y = PosLim; sat = 1'b1; end
    if (y < NegLim) begin y = NegLim; sat = 1'b1; end
    cap = (y < 0);

    if (cap) begin
      ax = 64'(-y);
      if (f != 0) begin
        elem = (CapNum / f) / ax;
        if (elem > 64'(Max48U)) begin
          elem = 64'(Max48U);
          sat  = 1'b1;
        end
      end
      // parallel resistance, zero real part pins it to the maximum
      if (x == 0) begin
        eqr = PosLim;
        sat = 1'b1;
      end else begin
        ar  = (x < 0) ? 64'(-x) : 64'(x);
        num = 128'(ar) * 128'(ar) + 128'(ax) * 128'(ax);
        q   = num / 128'(ar);
        if (q > 128'(Max48S)) begin
          q   = 128'(Max48S);
          sat = 1'b1;
        end
        eqr = (x < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
      end
    end else begin
      if (f != 0) begin
        num = 128'(64'(y)) * 128'(IndNum);
        q   = num / (128'(f) << 32);
        if (q > 128'(Max48U)) begin
          q   = 128'(Max48U);
          sat = 1'b1;
        end
        elem = q[63:0];
      end
      eqr = x;
    end

    r.real_part = x[47:0];
    r.imag_part = y[47:0];
    r.is_cap    = cap;
    r.elem      = elem[47:0];
    r.eqr       = eqr[47:0];
    r.status    = (f == 0) ? StZeroFreq : (sat ? StSat : StOk);
    return r;
  endfunction

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [23:0]        amplitude_ratio_i = '0;
  logic signed [16:0] phase_deg_i = '0;
  logic [15:0]        voltage_gain_i = '0;
  logic [23:0]        transimpedance_gain_i = '0;
  logic [15:0]        current_gain_i = '0;
  logic [19:0]        frequency_hz_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [47:0] real_part_o;
  logic signed [47:0] imag_part_o;
  logic               is_capacitive_o;
  logic [47:0]        element_value_o;
  logic signed [47:0] equivalent_resistance_o;
  logic [1:0]         status_o;

  impedance_scoreboard sb = new();
  // quiet: no idling on either side
  logic quiet = 1'b0;
  int   idle_cycles = 0;

  impedance_from_ratio_and_phase_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  // receiver stalls at random except in the quiet stretch
  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < IdlePct);
  end

  // output monitor, values sampled before the edge updates them
  always @(posedge clk_i) begin
    out_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.real_part = real_part_o;
      got.imag_part = imag_part_o;
      got.is_cap    = is_capacitive_o;
      got.elem      = element_value_o;
      got.eqr       = equivalent_resistance_o;
      got.status    = status_o;
      sb.check_result(got);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= QuietLimit) begin
      $display("impedance_from_ratio_and_phase_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one measurement transfer, with a random gap in front
  task automatic drive_measurement(in_t m);
    while (!quiet && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    amplitude_ratio_i     <= m.ratio;
    phase_deg_i           <= m.phase;
    voltage_gain_i        <= m.vg;
    transimpedance_gain_i <= m.tz;
    current_gain_i        <= m.cg;
    frequency_hz_i        <= m.f;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_measurement(m);
  endtask

  function automatic in_t random_measurement();
    in_t m;
    int  sel;
    sel = $urandom_range(99);
    // ratio around unity half of the time, full range otherwise
    m.ratio = (sel < 50) ? 24'($urandom_range(32'h3FFFF)) : 24'($urandom);
    sel = $urandom_range(99);
    if (sel < 80)      m.phase = 17'($signed($urandom_range(92160)) - 46080);
    else if (sel < 90) m.phase = 17'($urandom);
    else               m.phase = 17'(23040 * ($signed($urandom_range(8)) - 4));
    m.vg = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom);
    m.cg = ($urandom_range(19) == 0) ? 16'd0 :
           ($urandom_range(1) ? 16'($urandom) : 16'($urandom_range(16)));
    m.tz = ($urandom_range(19) == 0) ? 24'd0 :
           ($urandom_range(1) ? 24'($urandom) : 24'($urandom_range(100000)));
    sel = $urandom_range(99);
    if (sel < 5)       m.f = 20'd0;
    else if (sel < 55) m.f = 20'($urandom);
    else               m.f = 20'($urandom_range(1, 100000));
    return m;
  endfunction

  function automatic in_t make_measurement(logic [23:0] ratio, logic signed [16:0] phase,
                                           logic [15:0] vg, logic [23:0] tz,
                                           logic [15:0] cg, logic [19:0] f);
    in_t m;
    m.ratio = ratio;
    m.phase = phase;
    m.vg    = vg;
    m.tz    = tz;
    m.cg    = cg;
    m.f     = f;
    return m;
  endfunction

  initial begin
    in_t directed[$];
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, quadrant edges, phase wrap, zero gains and zero frequency
    directed.push_back(make_measurement(24'h010000, 17'sd0, 16'd1, 24'd1000, 16'd1, 20'd1000));
    directed.push_back(make_measurement(24'h0, 17'sd0, 16'd1, 24'd1, 16'd1, 20'd1));
    directed.push_back(make_measurement(24'hFFFFFF, 17'sd0, 16'd0, 24'hFFFFFF, 16'hFFFF,
                                        20'hFFFFF));
    directed.push_back(make_measurement(24'h010000, 17'sd23040, 16'd1, 24'd1000, 16'd1,
                                        20'd1000));
    directed.push_back(make_measurement(24'h010000, -17'sd23040, 16'd1, 24'd1000, 16'd1,
                                        20'd1000));
    directed.push_back(make_measurement(24'h010000, 17'sd46080, 16'd1, 24'd1000, 16'd1,
                                        20'd50));
    directed.push_back(make_measurement(24'h010000, -17'sd46080, 16'd1, 24'd1000, 16'd1,
                                        20'd50));
    directed.push_back(make_measurement(24'h008000, 17'sd11520, 16'd2, 24'd500, 16'd3,
                                        20'd0));
    directed.push_back(make_measurement(24'h008000, -17'sd11520, 16'hFFFF, 24'd0, 16'd0,
                                        20'd0));
    directed.push_back(make_measurement(24'h123456, 17'sd65535, 16'd7, 24'd99, 16'd5,
                                        20'd12345));
    directed.push_back(make_measurement(24'h123456, -17'sd65536, 16'd7, 24'd99, 16'd5,
                                        20'd12345));
    directed.push_back(make_measurement(24'hFFFFFF, 17'sd34560, 16'd1, 24'hFFFFFF, 16'hFFFF,
                                        20'd1));
    directed.push_back(make_measurement(24'hFFFFFF, -17'sd34560, 16'd1, 24'hFFFFFF, 16'hFFFF,
                                        20'd1));
    directed.push_back(make_measurement(24'h000001, 17'sd100, 16'hFFFF, 24'd1, 16'd1,
                                        20'd1));
    directed.push_back(make_measurement(24'h000001, -17'sd100, 16'hFFFF, 24'd1, 16'd1,
                                        20'hFFFFF));
    directed.push_back(make_measurement(24'h020000, 17'sd23039, 16'd1, 24'd10, 16'd1,
                                        20'd1));
    directed.push_back(make_measurement(24'hFFFFFF, 17'sd23040, 16'd1, 24'hFFFFFF, 16'hFFFF,
                                        20'hFFFFF));
    directed.push_back(make_measurement(24'h0, 17'sd23040, 16'd1, 24'd1, 16'd1, 20'd10));
    foreach (directed[i]) drive_measurement(directed[i]);

    for (int n = 0; n < NumRandom; n++) begin
      quiet = (n >= 600 && n < 900);
      // once, let the pipeline drain completely before going on
      if (n == 1000) begin
        in_valid_i <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk_i);
      end
      drive_measurement(random_measurement());
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("impedance_from_ratio_and_phase_unit regression: pass");
    end else begin
      $display("impedance_from_ratio_and_phase_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- impedance_from_ratio_and_phase_unit.f -----
hdl/izr_pkg.sv
hdl/izr_front.sv
hdl/izr_cordic.sv
hdl/izr_back.sv
hdl/impedance_from_ratio_and_phase_unit.sv
sim/testbench.sv
